// File: sv/pdl_pkg.sv
// Shared sizes, codes and types of the positional doubly linked list.
`timescale 1ns / 1ps
`default_nettype none
package pdl_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ACT_W       = 2;
  localparam int ST_W        = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_POP    = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_SOLE = 2'd0,
    KIND_HEAD = 2'd1,
    KIND_TAIL = 2'd2,
    KIND_MID  = 2'd3
  } kind_e;

endpackage
`default_nettype wire

// File: sv/pdl_if.sv
// Request and response channel interfaces of the positional doubly linked list.
`timescale 1ns / 1ps
`default_nettype none
interface pdl_req_if import pdl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [ACT_W-1:0]              action;
  logic [CNT_W-1:0]              position;
  logic signed [VALUE_WIDTH-1:0] item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface pdl_rsp_if import pdl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] removed_value;
  logic [ST_W-1:0]               status;
  logic [CNT_W-1:0]              count_after;

  modport source (output valid, removed_value, status, count_after, input ready);
  modport sink   (input valid, removed_value, status, count_after, output ready);
endinterface
`default_nettype wire

// File: sv/pdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/positional_doubly_linked_list.sv
// Top level: sequencer of the positional doubly linked list over slot memories.
//
//   channel  dir  handshake    payload
//   req_i    in   valid/ready  action, position, item_value
//   rsp_o    out  valid/ready  removed_value, status, count_after
//
// A failed request goes from S_DECIDE straight to S_FINISH. Pop, remove and inserts
// inside the list walk to the position; append and inserts at either end do not. The
// walk reads one link per cycle from the nearer end, at most CAPACITY/2 steps. Reset
// clears control state only; the block is ready in the first cycle after reset. A
// response waits in the output register while the next request is accepted;
// processing holds in its last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module positional_doubly_linked_list import pdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdl_req_if.sink   req_i,
  pdl_rsp_if.source rsp_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECIDE  = 10'b0000000010,
    S_ALLOC   = 10'b0000000100,
    S_SEEK    = 10'b0000001000,
    S_WALK    = 10'b0000010000,
    S_READ    = 10'b0000100000,
    S_LINK    = 10'b0001000000,
    S_WRITE_A = 10'b0010000000,
    S_WRITE_B = 10'b0100000000,
    S_FINISH  = 10'b1000000000
  } state_e;

  state_e                 state_q, state_d;
  action_e                act_q, act_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]       epos_q, epos_d;
  kind_e                  kind_q, kind_d;
  logic                   is_ins_q, is_ins_d;
  logic                   dir_q, dir_d;
  logic [CNT_W-1:0]       steps_q, steps_d;
  logic [SLOT_W-1:0]      cur_q, cur_d;
  logic [SLOT_W-1:0]      s_q, s_d;
  logic [SLOT_W-1:0]      nxt_q, nxt_d;
  logic [SLOT_W-1:0]      prv_q, prv_d;
  logic                   has_nxt_q, has_nxt_d;
  logic                   has_prv_q, has_prv_d;
  logic [SLOT_W-1:0]      head_q, head_d;
  logic [SLOT_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       never_q, never_d;
  logic [CNT_W-1:0]       top_q, top_d;
  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
  status_e                res_st_q, res_st_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_val_q;
  status_e                out_st_q;
  logic [CNT_W-1:0]       out_cnt_q;
  logic                   out_load;

  logic                   dec_err;
  status_e                dec_st;
  logic                   dec_ins;
  logic [CNT_W-1:0]       dec_pos;
  logic                   fwd;
  logic [SLOT_W-1:0]      start;
  logic [CNT_W-1:0]       steps;
  logic [SLOT_W-1:0]      link;
  logic [CNT_W-1:0]       top_m1;
  logic [CNT_W-1:0]       cnt_m1;

  logic                   val_we, val_re;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   nl_we, pl_we, link_re;
  logic [SLOT_W-1:0]      nl_waddr, nl_wdata, pl_waddr, pl_wdata, link_raddr;
  logic [SLOT_W-1:0]      nl_rdata, pl_rdata;
  logic                   rec_we, rec_re;
  logic [SLOT_W-1:0]      rec_rdata;

  assign top_m1 = top_q - CNT_W'(1);
  assign cnt_m1 = count_q - CNT_W'(1);
  assign fwd    = (epos_q <= (count_q >> 1));
  assign start  = fwd ? head_q : tail_q;
  assign steps  = fwd ? epos_q : (cnt_m1 - epos_q);
  assign link   = dir_q ? pl_rdata : nl_rdata;

  always_comb begin
    dec_err = 1'b0;
    dec_st  = ST_OK;
    dec_ins = 1'b0;
    dec_pos = pos_q;
    unique case (act_q)
      ACT_APPEND: begin
        dec_ins = 1'b1;
        dec_pos = count_q;
        if (count_q == CNT_W'(CAPACITY)) begin
          dec_err = 1'b1;
          dec_st  = ST_FULL;
        end
      end
      ACT_POP: begin
        dec_pos = cnt_m1;
        if (count_q == '0) begin
          dec_err = 1'b1;
          dec_st  = ST_EMPTY;
        end
      end
      ACT_INSERT: begin
        dec_ins = 1'b1;
        if (pos_q > count_q) begin
          dec_err = 1'b1;
          dec_st  = ST_RANGE;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          dec_err = 1'b1;
          dec_st  = ST_FULL;
        end
      end
      default: begin
        if (count_q == '0) begin
          dec_err = 1'b1;
          dec_st  = ST_EMPTY;
        end else if (pos_q >= count_q) begin
          dec_err = 1'b1;
          dec_st  = ST_RANGE;
        end
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    pos_d       = pos_q;
    val_d       = val_q;
    epos_d      = epos_q;
    kind_d      = kind_q;
    is_ins_d    = is_ins_q;
    dir_d       = dir_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    s_d         = s_q;
    nxt_d       = nxt_q;
    prv_d       = prv_q;
    has_nxt_d   = has_nxt_q;
    has_prv_d   = has_prv_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    never_d     = never_q;
    top_d       = top_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_load    = 1'b0;
    val_we      = 1'b0;
    val_re      = 1'b0;
    nl_we       = 1'b0;
    nl_waddr    = s_q;
    nl_wdata    = '0;
    pl_we       = 1'b0;
    pl_waddr    = s_q;
    pl_wdata    = '0;
    link_re     = 1'b0;
    link_raddr  = link;
    rec_we      = 1'b0;
    rec_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d   = action_e'(req_i.action);
          pos_d   = req_i.position;
          val_d   = req_i.item_value;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_val_d = '0;
        res_st_d  = dec_st;
        epos_d    = dec_pos;
        is_ins_d  = dec_ins;
        if (dec_ins) begin
          if (count_q == '0) begin
            kind_d = KIND_SOLE;
          end else if (dec_pos == count_q) begin
            kind_d = KIND_TAIL;
          end else if (dec_pos == '0) begin
            kind_d = KIND_HEAD;
          end else begin
            kind_d = KIND_MID;
          end
        end else begin
          if (count_q == CNT_W'(1)) begin
            kind_d = KIND_SOLE;
          end else if (dec_pos == '0) begin
            kind_d = KIND_HEAD;
          end else if (dec_pos == cnt_m1) begin
            kind_d = KIND_TAIL;
          end else begin
            kind_d = KIND_MID;
          end
        end
        if (dec_err) begin
          state_d = S_FINISH;
        end else if (dec_ins) begin
          rec_re  = (top_q != '0);
          state_d = S_ALLOC;
        end else begin
          state_d = S_SEEK;
        end
      end
      S_ALLOC: begin
        if (top_q != '0) begin
          s_d   = rec_rdata;
          top_d = top_m1;
        end else begin
          s_d     = never_q[SLOT_W-1:0];
          never_d = never_q + CNT_W'(1);
        end
        nxt_d     = head_q;
        prv_d     = tail_q;
        has_nxt_d = (kind_q == KIND_HEAD);
        has_prv_d = (kind_q == KIND_TAIL);
        state_d   = (kind_q == KIND_MID) ? S_SEEK : S_WRITE_A;
      end
      S_SEEK: begin
        dir_d      = !fwd;
        link_raddr = start;
        if (steps == '0) begin
          cur_d   = start;
          state_d = S_READ;
        end else begin
          link_re = 1'b1;
          steps_d = steps - CNT_W'(1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          cur_d   = link;
          state_d = S_READ;
        end else begin
          link_re = 1'b1;
          steps_d = steps_q - CNT_W'(1);
        end
      end
      S_READ: begin
        link_re    = 1'b1;
        link_raddr = cur_q;
        val_re     = 1'b1;
        state_d    = S_LINK;
      end
      S_LINK: begin
        if (is_ins_q) begin
          nxt_d     = cur_q;
          prv_d     = pl_rdata;
          has_nxt_d = 1'b1;
          has_prv_d = 1'b1;
          state_d   = S_WRITE_A;
        end else begin
          res_val_d = val_rdata;
          rec_we    = 1'b1;
          top_d     = top_q + CNT_W'(1);
          count_d   = cnt_m1;
          case (kind_q)
            KIND_HEAD: begin
              head_d   = nl_rdata;
              pl_we    = 1'b1;
              pl_waddr = nl_rdata;
            end
            KIND_TAIL: begin
              tail_d   = pl_rdata;
              nl_we    = 1'b1;
              nl_waddr = pl_rdata;
            end
            KIND_MID: begin
              nl_we    = 1'b1;
              nl_waddr = pl_rdata;
              nl_wdata = nl_rdata;
              pl_we    = 1'b1;
              pl_waddr = nl_rdata;
              pl_wdata = pl_rdata;
            end
            default: ;
          endcase
          state_d = S_FINISH;
        end
      end
      S_WRITE_A: begin
        val_we   = 1'b1;
        nl_we    = 1'b1;
        nl_wdata = has_nxt_q ? nxt_q : '0;
        pl_we    = 1'b1;
        pl_wdata = has_prv_q ? prv_q : '0;
        state_d  = S_WRITE_B;
      end
      S_WRITE_B: begin
        if (has_prv_q) begin
          nl_we    = 1'b1;
          nl_waddr = prv_q;
          nl_wdata = s_q;
        end
        if (has_nxt_q) begin
          pl_we    = 1'b1;
          pl_waddr = nxt_q;
          pl_wdata = s_q;
        end
        count_d = count_q + CNT_W'(1);
        case (kind_q)
          KIND_SOLE: begin
            head_d = s_q;
            tail_d = s_q;
          end
          KIND_TAIL: tail_d = s_q;
          KIND_HEAD: head_d = s_q;
          default: ;
        endcase
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_load || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      never_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      never_q     <= never_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    epos_q    <= epos_d;
    kind_q    <= kind_d;
    is_ins_q  <= is_ins_d;
    dir_q     <= dir_d;
    steps_q   <= steps_d;
    cur_q     <= cur_d;
    s_q       <= s_d;
    nxt_q     <= nxt_d;
    prv_q     <= prv_d;
    has_nxt_q <= has_nxt_d;
    has_prv_q <= has_prv_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= count_q;
    end
  end

  pdl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (s_q),
    .wdata_i (val_q),
    .re_i    (val_re),
    .raddr_i (cur_q),
    .rdata_o (val_rdata)
  );

  pdl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (nl_rdata)
  );

  pdl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (pl_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (pl_rdata)
  );

  pdl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (top_q[SLOT_W-1:0]),
    .wdata_i (cur_q),
    .re_i    (rec_re),
    .raddr_i (top_m1[SLOT_W-1:0]),
    .rdata_o (rec_rdata)
  );

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_val_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.count_after   = out_cnt_q;

endmodule
`default_nettype wire

// File: sv/pdl_checker.sv
// Port-level assertions of the positional doubly linked list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pdl_checker import pdl_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [VALUE_WIDTH-1:0] removed_value_i,
  input logic [ST_W-1:0]        status_i,
  input logic [CNT_W-1:0]       count_after_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(removed_value_i)
      && $stable(status_i) && $stable(count_after_i))
    else $error("response changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> count_after_i <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> removed_value_i == '0)
    else $error("failed request returned a value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_FULL |-> count_after_i == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |-> count_after_i == '0)
    else $error("empty status with elements held");

endmodule

bind positional_doubly_linked_list pdl_checker u_pdl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .removed_value_i (rsp_o.removed_value),
  .status_i        (rsp_o.status),
  .count_after_i   (rsp_o.count_after)
);
`default_nettype wire
